// ===== sv/pia_pkg.sv =====
// ----------------------------------------------------------------------------
// pia_pkg
// Shared widths, types and outcome codes of the intercept aim pipeline.
// ----------------------------------------------------------------------------
package pia_pkg;

   localparam int POS_W  = 32;
   localparam int VEL_W  = 24;
   localparam int FRAC_W = 17;
   localparam int DIF_W  = POS_W + 1;
   localparam int A_W    = 50;
   localparam int B_W    = 59;
   localparam int C_W    = 66;
   localparam int D_W    = 117;
   localparam int ROOT_W = 59;
   localparam int DEN_W  = ROOT_W + 2;
   localparam int TIME_W = 32;
   localparam int NUM_W  = C_W + 17;

   localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

   typedef enum logic [2:0] {
      OUTCOME_LEAD       = 3'd0,
      OUTCOME_FRAC_ZERO  = 3'd1,
      OUTCOME_SPEED_ZERO = 3'd2,
      OUTCOME_NO_ROOT    = 3'd3,
      OUTCOME_AT_TARGET  = 3'd4
   } outcome_type;

   typedef struct packed {
      logic [2:0][POS_W-1:0] shooter;
      logic [2:0][POS_W-1:0] target;
      logic [2:0][VEL_W-1:0] vel;
      logic [VEL_W-1:0]      speed;
      logic [FRAC_W-1:0]     frac;
   } req_type;

   typedef struct packed {
      logic [2:0][POS_W-1:0] tgt;
      logic [2:0][VEL_W-1:0] vel;
      logic [FRAC_W-1:0]     frac;
      outcome_type           outcome;
   } ctx_type;

   typedef struct packed {
      ctx_type          ctx;
      logic [B_W-1:0]   b;
      logic [C_W-1:0]   c;
      logic [D_W-1:0]   d;
   } quad_out_type;

   typedef struct packed {
      ctx_type           ctx;
      logic [B_W-1:0]    b;
      logic [C_W-1:0]    c;
      logic [ROOT_W-1:0] root;
   } sqrt_out_type;

   typedef struct packed {
      ctx_type           ctx;
      logic [TIME_W-1:0] time_q;
   } div_out_type;

   typedef struct packed {
      logic [2:0][POS_W-1:0] aim;
      logic [TIME_W-1:0]     time_q;
      outcome_type           outcome;
   } aim_out_type;

endpackage

// ===== sv/pia_quad.sv =====
// ----------------------------------------------------------------------------
// pia_quad
// Six stages: offsets, products, quadratic coefficients, split partial products,
// discriminant terms, discriminant and root-exists check.
// ----------------------------------------------------------------------------
module pia_quad
   import pia_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  req_type      in_req,
   output logic         out_valid,
   output quad_out_type out_data
);

   localparam int PV_W = DIF_W + VEL_W;
   localparam int PP_W = 2 * DIF_W - 1;
   localparam int VV_W = 2 * VEL_W - 1;
   localparam int SS_W = 2 * VEL_W;
   localparam int BM_W = B_W - 1;
   localparam int BS_W = BM_W / 2;
   localparam int AM_W = 48;
   localparam int CS_W = C_W / 3;
   localparam int AS_W = AM_W / 2;
   localparam int BP_W = 2 * (BM_W - BS_W);
   localparam int AP_W = CS_W + AS_W;

   typedef struct packed {
      logic apos;
      logic aneg;
      logic bneg;
   } sign_type;

   logic [5:0] valid_ff;

   logic [2:0][DIF_W-1:0] s1_p_ff, s1_p_in;
   ctx_type               s1_ctx_ff, s1_ctx_in;
   logic [VEL_W-1:0]      s1_speed_ff;

   logic [2:0][PV_W-1:0]  s2_pv_ff, s2_pv_in;
   logic [2:0][PP_W-1:0]  s2_pp_ff, s2_pp_in;
   logic [2:0][VV_W-1:0]  s2_vv_ff, s2_vv_in;
   logic [SS_W-1:0]       s2_ss_ff, s2_ss_in;
   ctx_type               s2_ctx_ff, s2_ctx_in;

   logic [A_W-1:0]        s3_a_ff, s3_a_in;
   logic [B_W-1:0]        s3_b_ff, s3_b_in;
   logic [C_W-1:0]        s3_c_ff, s3_c_in;
   ctx_type               s3_ctx_ff;

   logic [2:0][BP_W-1:0]  s4_bp_ff, s4_bp_in;
   logic [5:0][AP_W-1:0]  s4_ap_ff, s4_ap_in;
   sign_type              s4_sign_ff, s4_sign_in;
   logic [B_W-1:0]        s4_b_ff;
   logic [C_W-1:0]        s4_c_ff;
   ctx_type               s4_ctx_ff;

   logic [D_W-1:0]        s5_bb_ff, s5_bb_in;
   logic [D_W-1:0]        s5_ac4_ff, s5_ac4_in;
   sign_type              s5_sign_ff;
   logic [B_W-1:0]        s5_b_ff;
   logic [C_W-1:0]        s5_c_ff;
   ctx_type               s5_ctx_ff;

   quad_out_type          s6_ff, s6_in;

   always_comb begin
      s1_ctx_in.tgt  = in_req.target;
      s1_ctx_in.vel  = in_req.vel;
      s1_ctx_in.frac = (in_req.frac > FRAC_ONE) ? FRAC_ONE : in_req.frac;
      if (in_req.frac == '0) begin
         s1_ctx_in.outcome = OUTCOME_FRAC_ZERO;
      end else if (in_req.speed == '0) begin
         s1_ctx_in.outcome = OUTCOME_SPEED_ZERO;
      end else begin
         s1_ctx_in.outcome = OUTCOME_LEAD;
      end
      for (int i = 0; i < 3; i++) begin
         s1_p_in[i] = {in_req.target[i][POS_W-1], in_req.target[i]}
                    - {in_req.shooter[i][POS_W-1], in_req.shooter[i]};
      end
   end

   always_comb begin
      logic signed [PV_W-1:0]   pv;
      logic signed [PP_W:0]     pp;
      logic signed [VV_W:0]     vv;
      for (int i = 0; i < 3; i++) begin
         pv = $signed(s1_p_ff[i]) * $signed(s1_ctx_ff.vel[i]);
         pp = $signed(s1_p_ff[i]) * $signed(s1_p_ff[i]);
         vv = $signed(s1_ctx_ff.vel[i]) * $signed(s1_ctx_ff.vel[i]);
         s2_pv_in[i] = pv;
         s2_pp_in[i] = pp[PP_W-1:0];
         s2_vv_in[i] = vv[VV_W-1:0];
      end
      s2_ss_in  = SS_W'(s1_speed_ff) * SS_W'(s1_speed_ff);
      s2_ctx_in = s1_ctx_ff;
      if (s1_ctx_ff.outcome == OUTCOME_LEAD && s1_p_ff == '0) begin
         s2_ctx_in.outcome = OUTCOME_AT_TARGET;
      end
   end

   always_comb begin
      logic signed [B_W-1:0] pv_sum;
      pv_sum = B_W'($signed(s2_pv_ff[0])) + B_W'($signed(s2_pv_ff[1]))
             + B_W'($signed(s2_pv_ff[2]));
      s3_b_in = {pv_sum[B_W-2:0], 1'b0};
      s3_a_in = A_W'(s2_vv_ff[0]) + A_W'(s2_vv_ff[1]) + A_W'(s2_vv_ff[2])
              - A_W'(s2_ss_ff);
      s3_c_in = C_W'(s2_pp_ff[0]) + C_W'(s2_pp_ff[1]) + C_W'(s2_pp_ff[2]);
   end

   always_comb begin
      logic [A_W-1:0] amag;
      logic [B_W-1:0] bmag;
      amag = s3_a_ff[A_W-1] ? (~s3_a_ff + A_W'(1)) : s3_a_ff;
      bmag = s3_b_ff[B_W-1] ? (~s3_b_ff + B_W'(1)) : s3_b_ff;
      s4_bp_in[0] = BP_W'(bmag[BS_W-1:0]) * BP_W'(bmag[BS_W-1:0]);
      s4_bp_in[1] = BP_W'(bmag[BM_W-1:BS_W]) * BP_W'(bmag[BS_W-1:0]);
      s4_bp_in[2] = BP_W'(bmag[BM_W-1:BS_W]) * BP_W'(bmag[BM_W-1:BS_W]);
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 2; k++) begin
            s4_ap_in[2*j+k] = AP_W'(s3_c_ff[CS_W*j +: CS_W])
                            * AP_W'(amag[AS_W*k +: AS_W]);
         end
      end
      s4_sign_in.apos = !s3_a_ff[A_W-1] && (s3_a_ff != '0);
      s4_sign_in.aneg = s3_a_ff[A_W-1];
      s4_sign_in.bneg = s3_b_ff[B_W-1];
   end

   always_comb begin
      logic [D_W-1:0] ac;
      s5_bb_in = (D_W'(s4_bp_ff[2]) << (2*BS_W)) + (D_W'(s4_bp_ff[1]) << (BS_W+1))
               + D_W'(s4_bp_ff[0]);
      ac = '0;
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 2; k++) begin
            ac = ac + (D_W'(s4_ap_ff[2*j+k]) << (CS_W*j + AS_W*k));
         end
      end
      s5_ac4_in = {ac[D_W-3:0], 2'b00};
   end

   always_comb begin
      logic no_root;
      no_root = (!s5_sign_ff.aneg && !s5_sign_ff.bneg)
             || (s5_sign_ff.apos && (s5_bb_ff < s5_ac4_ff));
      s6_in.ctx = s5_ctx_ff;
      s6_in.b   = s5_b_ff;
      s6_in.c   = s5_c_ff;
      if (s5_sign_ff.apos) begin
         s6_in.d = s5_bb_ff - s5_ac4_ff;
      end else if (s5_sign_ff.aneg) begin
         s6_in.d = s5_bb_ff + s5_ac4_ff;
      end else begin
         s6_in.d = s5_bb_ff;
      end
      if (s5_ctx_ff.outcome == OUTCOME_LEAD && no_root) begin
         s6_in.ctx.outcome = OUTCOME_NO_ROOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_p_ff     <= s1_p_in;
         s1_ctx_ff   <= s1_ctx_in;
         s1_speed_ff <= in_req.speed;
         s2_pv_ff    <= s2_pv_in;
         s2_pp_ff    <= s2_pp_in;
         s2_vv_ff    <= s2_vv_in;
         s2_ss_ff    <= s2_ss_in;
         s2_ctx_ff   <= s2_ctx_in;
         s3_a_ff     <= s3_a_in;
         s3_b_ff     <= s3_b_in;
         s3_c_ff     <= s3_c_in;
         s3_ctx_ff   <= s2_ctx_ff;
         s4_bp_ff    <= s4_bp_in;
         s4_ap_ff    <= s4_ap_in;
         s4_sign_ff  <= s4_sign_in;
         s4_b_ff     <= s3_b_ff;
         s4_c_ff     <= s3_c_ff;
         s4_ctx_ff   <= s3_ctx_ff;
         s5_bb_ff    <= s5_bb_in;
         s5_ac4_ff   <= s5_ac4_in;
         s5_sign_ff  <= s4_sign_ff;
         s5_b_ff     <= s4_b_ff;
         s5_c_ff     <= s4_c_ff;
         s5_ctx_ff   <= s4_ctx_ff;
         s6_ff       <= s6_in;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_data  = s6_ff;

endmodule

// ===== sv/pia_sqrt.sv =====
// ----------------------------------------------------------------------------
// pia_sqrt
// Floor square root of the discriminant, one root bit per stage.
// ----------------------------------------------------------------------------
module pia_sqrt
   import pia_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  quad_out_type in_data,
   output logic         out_valid,
   output sqrt_out_type out_data
);

   typedef struct packed {
      ctx_type           ctx;
      logic [B_W-1:0]    b;
      logic [C_W-1:0]    c;
      logic [D_W-1:0]    rem;
      logic [ROOT_W-1:0] root;
   } sq_stage_type;

   logic [ROOT_W-1:0] valid_ff;
   sq_stage_type      st_ff [ROOT_W];
   sq_stage_type      st_in [ROOT_W];
   sq_stage_type      src   [ROOT_W];

   always_comb begin
      logic [D_W-1:0] trial;
      src[0].ctx  = in_data.ctx;
      src[0].b    = in_data.b;
      src[0].c    = in_data.c;
      src[0].rem  = in_data.d;
      src[0].root = '0;
      for (int i = 1; i < ROOT_W; i++) begin
         src[i] = st_ff[i-1];
      end
      for (int i = 0; i < ROOT_W; i++) begin
         // (root + 2^k)^2 - root^2
         trial = (D_W'(src[i].root) << (ROOT_W - i))
               + (D_W'(1) << (2 * (ROOT_W - 1 - i)));
         st_in[i] = src[i];
         if (trial <= src[i].rem) begin
            st_in[i].rem                 = src[i].rem - trial;
            st_in[i].root[ROOT_W-1-i]    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[ROOT_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < ROOT_W; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign out_valid     = valid_ff[ROOT_W-1];
   assign out_data.ctx  = st_ff[ROOT_W-1].ctx;
   assign out_data.b    = st_ff[ROOT_W-1].b;
   assign out_data.c    = st_ff[ROOT_W-1].c;
   assign out_data.root = st_ff[ROOT_W-1].root;

endmodule

// ===== sv/pia_div.sv =====
// ----------------------------------------------------------------------------
// pia_div
// Denominator, range check and restoring division for the Q16.16 time,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module pia_div
   import pia_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  sqrt_out_type in_data,
   output logic         out_valid,
   output div_out_type  out_data
);

   localparam int DV_W = DEN_W + TIME_W;
   localparam int NST  = TIME_W + 1;

   typedef struct packed {
      ctx_type           ctx;
      logic [DEN_W-1:0]  den;
      logic [DV_W-1:0]   rem;
      logic [TIME_W-1:0] quo;
      logic              sat;
   } dv_stage_type;

   logic [NST:0]  valid_ff;
   dv_stage_type  p0_ff, p0_in;
   dv_stage_type  st_ff [NST];
   dv_stage_type  st_in [NST];
   dv_stage_type  src   [NST];

   always_comb begin
      p0_in.ctx = in_data.ctx;
      p0_in.den = {2'b00, in_data.root} - {{2{in_data.b[B_W-1]}}, in_data.b};
      p0_in.rem = DV_W'({in_data.c, 17'b0});
      p0_in.quo = '0;
      p0_in.sat = 1'b0;
   end

   always_comb begin
      logic [DV_W-1:0] dk;
      src[0] = p0_ff;
      for (int i = 1; i < NST; i++) begin
         src[i] = st_ff[i-1];
      end
      st_in[0]     = src[0];
      st_in[0].sat = ($signed(src[0].den) <= 0)
                  || (src[0].rem >= (DV_W'(src[0].den) << TIME_W));
      for (int i = 1; i < NST; i++) begin
         dk       = DV_W'(src[i].den) << (TIME_W - i);
         st_in[i] = src[i];
         if (src[i].rem >= dk) begin
            st_in[i].rem              = src[i].rem - dk;
            st_in[i].quo[TIME_W-i]    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NST-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff <= p0_in;
         for (int i = 0; i < NST; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   always_comb begin
      out_data.ctx = st_ff[NST-1].ctx;
      if (st_ff[NST-1].ctx.outcome != OUTCOME_LEAD) begin
         out_data.time_q = '0;
      end else if (st_ff[NST-1].sat) begin
         out_data.time_q = '1;
      end else begin
         out_data.time_q = st_ff[NST-1].quo;
      end
   end

   assign out_valid = valid_ff[NST];

endmodule

// ===== sv/pia_aim.sv =====
// ----------------------------------------------------------------------------
// pia_aim
// Scales the time by the lead fraction, forms the per-axis lead offset and
// adds it to the target with saturation.
// ----------------------------------------------------------------------------
module pia_aim
   import pia_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  div_out_type in_data,
   output logic        out_valid,
   output aim_out_type out_data
);

   localparam int EP_W = TIME_W + FRAC_W;
   localparam int MP_W = VEL_W + TIME_W;
   localparam int M_W  = MP_W - 16;
   localparam int S_W  = POS_W + 10;

   logic [2:0]              valid_ff;

   logic [EP_W-1:0]         sa_prod_ff, sa_prod_in;
   div_out_type             sa_data_ff;

   logic [2:0][MP_W-1:0]    sb_prod_ff, sb_prod_in;
   logic [2:0]              sb_neg_ff;
   div_out_type             sb_data_ff;

   aim_out_type             sc_ff, sc_in;

   assign sa_prod_in = EP_W'(in_data.time_q) * EP_W'(in_data.ctx.frac);

   always_comb begin
      logic [TIME_W-1:0] eff;
      logic [VEL_W-1:0]  vmag;
      eff = sa_prod_ff[TIME_W+15:16];
      for (int i = 0; i < 3; i++) begin
         vmag = sa_data_ff.ctx.vel[i][VEL_W-1] ? (~sa_data_ff.ctx.vel[i] + VEL_W'(1))
                                               : sa_data_ff.ctx.vel[i];
         sb_prod_in[i] = MP_W'(vmag) * MP_W'(eff);
      end
   end

   always_comb begin
      logic signed [S_W-1:0] off;
      logic signed [S_W-1:0] sum;
      for (int i = 0; i < 3; i++) begin
         off = $signed(S_W'(sb_prod_ff[i][MP_W-1:16]));
         if (sb_neg_ff[i]) begin
            off = -off;
         end
         sum = S_W'($signed(sb_data_ff.ctx.tgt[i])) + off;
         if (!sum[S_W-1] && (sum[S_W-2:POS_W-1] != '0)) begin
            sc_in.aim[i] = {1'b0, {(POS_W-1){1'b1}}};
         end else if (sum[S_W-1] && (sum[S_W-2:POS_W-1] != '1)) begin
            sc_in.aim[i] = {1'b1, {(POS_W-1){1'b0}}};
         end else begin
            sc_in.aim[i] = sum[POS_W-1:0];
         end
      end
      sc_in.time_q  = sb_data_ff.time_q;
      sc_in.outcome = sb_data_ff.ctx.outcome;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_prod_ff <= sa_prod_in;
         sa_data_ff <= in_data;
         sb_prod_ff <= sb_prod_in;
         for (int i = 0; i < 3; i++) begin
            sb_neg_ff[i] <= sa_data_ff.ctx.vel[i][VEL_W-1];
         end
         sb_data_ff <= sa_data_ff;
         sc_ff      <= sc_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = sc_ff;

endmodule

// ===== sv/projectile_intercept_aim_core.sv =====
// Throughput: one transaction per cycle while req_stall is low; the depth is set
// by the one-bit-per-stage square root (59 stages) and divider (34 stages).
// The whole pipeline advances together; it holds only while a result waits in the
// output register and the last stage is full.
// Reset (synchronous) clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// projectile_intercept_aim_core
// Lead aim point from shooter, target, target velocity, shot speed and lead
// fraction via the smallest positive intercept time.
// ----------------------------------------------------------------------------
module projectile_intercept_aim_core
   import pia_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [POS_W-1:0]  req_shooter_x,
   input  logic signed [POS_W-1:0]  req_shooter_y,
   input  logic signed [POS_W-1:0]  req_shooter_z,
   input  logic signed [POS_W-1:0]  req_target_x,
   input  logic signed [POS_W-1:0]  req_target_y,
   input  logic signed [POS_W-1:0]  req_target_z,
   input  logic signed [VEL_W-1:0]  req_velocity_x,
   input  logic signed [VEL_W-1:0]  req_velocity_y,
   input  logic signed [VEL_W-1:0]  req_velocity_z,
   input  logic [VEL_W-1:0]         req_shot_speed,
   input  logic [FRAC_W-1:0]        req_lead_fraction,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [POS_W-1:0]  rsp_aim_x,
   output logic signed [POS_W-1:0]  rsp_aim_y,
   output logic signed [POS_W-1:0]  rsp_aim_z,
   output logic [TIME_W-1:0]        rsp_intercept_time,
   output logic [2:0]               rsp_outcome
);

   logic         advance;
   req_type      req;
   logic         quad_valid, sqrt_valid, div_valid, aim_valid;
   quad_out_type quad_data;
   sqrt_out_type sqrt_data;
   div_out_type  div_data;
   aim_out_type  aim_data;
   logic         rsp_valid_ff;
   aim_out_type  rsp_data_ff;

   assign advance   = !aim_valid || !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      req.shooter[0] = req_shooter_x;
      req.shooter[1] = req_shooter_y;
      req.shooter[2] = req_shooter_z;
      req.target[0]  = req_target_x;
      req.target[1]  = req_target_y;
      req.target[2]  = req_target_z;
      req.vel[0]     = req_velocity_x;
      req.vel[1]     = req_velocity_y;
      req.vel[2]     = req_velocity_z;
      req.speed      = req_shot_speed;
      req.frac       = req_lead_fraction;
   end

   pia_quad u_quad (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (req_valid),
      .in_req    (req),
      .out_valid (quad_valid),
      .out_data  (quad_data)
   );

   pia_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (quad_valid),
      .in_data   (quad_data),
      .out_valid (sqrt_valid),
      .out_data  (sqrt_data)
   );

   pia_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (sqrt_valid),
      .in_data   (sqrt_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   pia_aim u_aim (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (aim_valid),
      .out_data  (aim_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= aim_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_data_ff <= aim_data;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_aim_x          = rsp_data_ff.aim[0];
   assign rsp_aim_y          = rsp_data_ff.aim[1];
   assign rsp_aim_z          = rsp_data_ff.aim[2];
   assign rsp_intercept_time = rsp_data_ff.time_q;
   assign rsp_outcome        = rsp_data_ff.outcome;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for projectile_intercept_aim_core: a directed table of
// aim queries followed by random queries, every result compared against its
// row value or an exact integer model of the solve, under varied flow control.
// ----------------------------------------------------------------------------
module testbench;
   import pia_pkg::*;

   typedef struct {
      logic signed [POS_W-1:0] sx, sy, sz, tx, ty, tz;
      logic signed [VEL_W-1:0] vx, vy, vz;
      logic [VEL_W-1:0]        speed;
      logic [FRAC_W-1:0]       frac;
   } aim_query_t;

   typedef struct {
      logic signed [POS_W-1:0] ax, ay, az;
      logic [TIME_W-1:0]       tm;
      outcome_type             outcome;
   } aim_result_t;

   typedef struct {
      aim_query_t  q;
      bit          typed;
      aim_result_t r;
   } table_row_t;

   localparam int IDLE_LIMIT = 20000;

   logic                    clock, reset;
   logic                    req_valid, req_stall;
   logic signed [POS_W-1:0] req_shooter_x, req_shooter_y, req_shooter_z;
   logic signed [POS_W-1:0] req_target_x, req_target_y, req_target_z;
   logic signed [VEL_W-1:0] req_velocity_x, req_velocity_y, req_velocity_z;
   logic [VEL_W-1:0]        req_shot_speed;
   logic [FRAC_W-1:0]       req_lead_fraction;
   logic                    rsp_valid, rsp_stall;
   logic signed [POS_W-1:0] rsp_aim_x, rsp_aim_y, rsp_aim_z;
   logic [TIME_W-1:0]       rsp_intercept_time;
   logic [2:0]              rsp_outcome;

   aim_result_t pending_aims[$];
   table_row_t  directed_rows[$];
   int          mismatches = 0;
   int          send_pct = 0, recv_pct = 0;
   int          hold_left = 0;
   int          idle_cycles = 0;

   projectile_intercept_aim_core dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic aim_result_t predict_aim(aim_query_t q);
      longint            p[3], v[3], t[3];
      longint            a, b, den, off, sum;
      longint unsigned   s, fr, tm, eff, m, ma, mb, pm;
      logic [255:0]      c, bb, ac4, d, num, root, cand;
      logic signed [POS_W-1:0] aim[3];
      outcome_type       oc;
      aim_result_t       r;
      t[0] = q.tx; t[1] = q.ty; t[2] = q.tz;
      p[0] = t[0] - longint'(q.sx);
      p[1] = t[1] - longint'(q.sy);
      p[2] = t[2] - longint'(q.sz);
      v[0] = q.vx; v[1] = q.vy; v[2] = q.vz;
      s = q.speed;
      fr = (q.frac > 65536) ? 65536 : q.frac;
      tm = 0;
      oc = OUTCOME_LEAD;
      if (fr == 0) oc = OUTCOME_FRAC_ZERO;
      else if (s == 0) oc = OUTCOME_SPEED_ZERO;
      else if (p[0] == 0 && p[1] == 0 && p[2] == 0) oc = OUTCOME_AT_TARGET;
      else begin
         a = v[0]*v[0] + v[1]*v[1] + v[2]*v[2] - longint'(s*s);
         b = 2 * (p[0]*v[0] + p[1]*v[1] + p[2]*v[2]);
         c = 0;
         for (int i = 0; i < 3; i++) begin
            pm = (p[i] < 0) ? -p[i] : p[i];
            c = c + 256'(pm) * 256'(pm);
         end
         ma = (a < 0) ? -a : a;
         mb = (b < 0) ? -b : b;
         bb = 256'(mb) * 256'(mb);
         ac4 = (c * 256'(ma)) << 2;
         if (a >= 0 && b >= 0) oc = OUTCOME_NO_ROOT;
         else if (a > 0 && bb < ac4) oc = OUTCOME_NO_ROOT;
         else begin
            if (a > 0) d = bb - ac4;
            else if (a < 0) d = bb + ac4;
            else d = bb;
            root = 0;
            for (int i = 62; i >= 0; i--) begin
               cand = root | (256'(1) << i);
               if (cand * cand <= d) root = cand;
            end
            den = longint'(root[63:0]) - b;
            num = c << 17;
            if (den <= 0 || num >= (256'(den) << 32)) tm = 64'hFFFF_FFFF;
            else tm = 64'(num / 256'(den));
         end
      end
      eff = (oc == OUTCOME_LEAD) ? (tm * fr) >> 16 : 0;
      for (int i = 0; i < 3; i++) begin
         m = (((v[i] < 0) ? -v[i] : v[i]) * eff) >> 16;
         off = (v[i] < 0) ? -longint'(m) : longint'(m);
         sum = t[i] + off;
         if (sum > 64'sd2147483647) aim[i] = 32'h7FFF_FFFF;
         else if (sum < -64'sd2147483648) aim[i] = 32'h8000_0000;
         else aim[i] = sum[31:0];
      end
      r.ax = aim[0]; r.ay = aim[1]; r.az = aim[2];
      r.tm = tm[31:0];
      r.outcome = oc;
      return r;
   endfunction

   function automatic aim_query_t mk_query(longint sx, sy, sz, tx, ty, tz,
                                           longint vx, vy, vz, sp, fr);
      aim_query_t q;
      q.sx = POS_W'(sx); q.sy = POS_W'(sy); q.sz = POS_W'(sz);
      q.tx = POS_W'(tx); q.ty = POS_W'(ty); q.tz = POS_W'(tz);
      q.vx = VEL_W'(vx); q.vy = VEL_W'(vy); q.vz = VEL_W'(vz);
      q.speed = VEL_W'(sp); q.frac = FRAC_W'(fr);
      return q;
   endfunction

   function automatic table_row_t mk_row(aim_query_t q, bit typed, longint ax, ay, az,
                                         longint tm, outcome_type oc);
      table_row_t row;
      row.q = q; row.typed = typed;
      row.r.ax = POS_W'(ax); row.r.ay = POS_W'(ay); row.r.az = POS_W'(az);
      row.r.tm = TIME_W'(tm); row.r.outcome = oc;
      return row;
   endfunction

   function automatic aim_query_t rand_query();
      aim_query_t q;
      int         roll;
      if ($urandom_range(0, 99) < 60) begin
         q.sx = $signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000;
         q.sy = $signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000;
         q.sz = $signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000;
         q.tx = $signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000;
         q.ty = $signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000;
         q.tz = $signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000;
         q.vx = VEL_W'($urandom_range(0, 32'h1_FFFF) - 32'h1_0000);
         q.vy = VEL_W'($urandom_range(0, 32'h1_FFFF) - 32'h1_0000);
         q.vz = VEL_W'($urandom_range(0, 32'h1_FFFF) - 32'h1_0000);
         q.speed = VEL_W'($urandom_range(1, 32'h4_0000));
         q.frac = FRAC_W'($urandom_range(1, 65536));
      end else begin
         q.sx = $urandom; q.sy = $urandom; q.sz = $urandom;
         q.tx = $urandom; q.ty = $urandom; q.tz = $urandom;
         q.vx = VEL_W'($urandom); q.vy = VEL_W'($urandom); q.vz = VEL_W'($urandom);
         q.speed = VEL_W'($urandom); q.frac = FRAC_W'($urandom);
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) q.frac = '0;
      else if (roll < 10) q.speed = '0;
      else if (roll < 15) begin
         q.sx = q.tx; q.sy = q.ty; q.sz = q.tz;
      end else if (roll < 20) q.frac = FRAC_W'($urandom_range(65537, 131071));
      return q;
   endfunction

   task automatic offer_query(aim_query_t q, bit typed, aim_result_t r);
      while ($urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_shooter_x <= q.sx; req_shooter_y <= q.sy; req_shooter_z <= q.sz;
      req_target_x <= q.tx; req_target_y <= q.ty; req_target_z <= q.tz;
      req_velocity_x <= q.vx; req_velocity_y <= q.vy; req_velocity_z <= q.vz;
      req_shot_speed <= q.speed;
      req_lead_fraction <= q.frac;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_aims.push_back(typed ? r : predict_aim(q));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_aims.size() == 0);
      @(posedge clock);
   endtask

   // receiver stall, with optional long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_pct);
      end
   end

   always @(posedge clock) begin
      aim_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_aims.size() == 0) begin
            $error("unexpected result transaction");
            mismatches++;
         end else begin
            want = pending_aims.pop_front();
            if (rsp_aim_x !== want.ax) begin
               $error("aim_x expected %0d got %0d", want.ax, rsp_aim_x);
               mismatches++;
            end
            if (rsp_aim_y !== want.ay) begin
               $error("aim_y expected %0d got %0d", want.ay, rsp_aim_y);
               mismatches++;
            end
            if (rsp_aim_z !== want.az) begin
               $error("aim_z expected %0d got %0d", want.az, rsp_aim_z);
               mismatches++;
            end
            if (rsp_intercept_time !== want.tm) begin
               $error("intercept_time expected %0h got %0h", want.tm, rsp_intercept_time);
               mismatches++;
            end
            if (rsp_outcome !== want.outcome) begin
               $error("outcome expected %0d got %0d", want.outcome, rsp_outcome);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      aim_result_t none;
      int          pcts[4][2];
      none.ax = '0;
      none.ay = '0;
      none.az = '0;
      none.tm = '0;
      none.outcome = OUTCOME_LEAD;
      pcts = '{'{0, 0}, '{64, 0}, '{0, 64}, '{16, 16}};
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_shooter_x = '0; req_shooter_y = '0; req_shooter_z = '0;
      req_target_x = '0; req_target_y = '0; req_target_z = '0;
      req_velocity_x = '0; req_velocity_y = '0; req_velocity_z = '0;
      req_shot_speed = '0; req_lead_fraction = '0;

      directed_rows.push_back(mk_row(mk_query(5, 6, 7, 100, -200, 300, 9, 9, 9, 512, 0),
                              1, 100, -200, 300, 0, OUTCOME_FRAC_ZERO));
      directed_rows.push_back(mk_row(mk_query(5, 6, 7, -100, 200, -300, 9, 9, 9, 0, 65536),
                              1, -100, 200, -300, 0, OUTCOME_SPEED_ZERO));
      directed_rows.push_back(mk_row(mk_query(77, -88, 99, 77, -88, 99, 300, 1, 2, 512, 40000),
                              1, 77, -88, 99, 0, OUTCOME_AT_TARGET));
      directed_rows.push_back(mk_row(mk_query(0, 0, 0, 256, 0, 0, 256, 0, 0, 256, 65536),
                              1, 256, 0, 0, 0, OUTCOME_NO_ROOT));
      directed_rows.push_back(mk_row(mk_query(0, 0, 0, 2560, 0, 0, 0, 0, 0, 256, 65536),
                              1, 2560, 0, 0, 655360, OUTCOME_LEAD));
      directed_rows.push_back(mk_row(mk_query(2560, 0, 0, 0, 0, 0, 256, 0, 0, 256, 65536),
                              1, 1280, 0, 0, 327680, OUTCOME_LEAD));
      directed_rows.push_back(mk_row(mk_query(0, 0, 0, 2560, 0, 0, 0, 512, 0, 256, 65536),
                              0, 0, 0, 0, 0, OUTCOME_LEAD));
      directed_rows.push_back(mk_row(mk_query(0, 0, 0, 2560, 0, 0, 0, 256, 0, 512, 131071),
                              0, 0, 0, 0, 0, OUTCOME_LEAD));
      directed_rows.push_back(mk_row(mk_query(0, 0, 0, 2560, 0, 0, 0, 256, 0, 512, 1),
                              0, 0, 0, 0, 0, OUTCOME_LEAD));
      directed_rows.push_back(mk_row(mk_query(0, 0, 0, 1, 0, 0, 0, 0, 0, 16777215, 65536),
                              0, 0, 0, 0, 0, OUTCOME_LEAD));
      directed_rows.push_back(mk_row(mk_query(-2147483648, -2147483648, -2147483648,
                              2147483647, 2147483647, 2147483647, 8388607, 8388607, 8388607,
                              16777215, 131071), 0, 0, 0, 0, 0, OUTCOME_LEAD));
      directed_rows.push_back(mk_row(mk_query(2147483647, 2147483647, 2147483647,
                              -2147483648, -2147483648, -2147483648, -8388608, -8388608,
                              -8388608, 16777215, 65536), 0, 0, 0, 0, 0, OUTCOME_LEAD));
      directed_rows.push_back(mk_row(mk_query(-2147483648, -2147483648, -2147483648,
                              2147483647, 2147483647, 2147483647, 8388607, 8388607, 8388607,
                              1, 65536), 0, 0, 0, 0, 0, OUTCOME_LEAD));
      directed_rows.push_back(mk_row(mk_query(2147483647, 0, 0, -2147483648, 0, 0,
                              -8388608, 0, 0, 8388608, 65536), 0, 0, 0, 0, 0, OUTCOME_LEAD));
      directed_rows.push_back(mk_row(mk_query(0, 0, 0, 2147483000, 0, 0, 8388607, 0, 0,
                              8388606, 65536), 0, 0, 0, 0, 0, OUTCOME_LEAD));
      directed_rows.push_back(mk_row(mk_query(-1, -1, -1, 0, 0, 0, -1, -1, -1, 16777215,
                              65535), 0, 0, 0, 0, 0, OUTCOME_LEAD));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_query(directed_rows[i].q, directed_rows[i].typed, directed_rows[i].r);
      drain_results();

      // long receiver hold-off while the sender keeps offering
      hold_left = 500;
      repeat (200) offer_query(rand_query(), 0, none);
      drain_results();

      for (int ph = 0; ph < 4; ph++) begin
         send_pct = pcts[ph][0];
         recv_pct = pcts[ph][1];
         repeat (300) offer_query(rand_query(), 0, none);
         drain_results();
      end
      send_pct = 0;
      recv_pct = 0;
      repeat (150) @(posedge clock);
      if (mismatches == 0 && pending_aims.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
